// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers used by the decoder rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ===== rtl/core/kmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// kmpd_pkg
// types, codes and the scan code table of the keyboard and mouse decoder
// ----------------------------------------------------------------------------
package kmpd_pkg;

  // key queue geometry, fixed by the fill count field width
  localparam int QUEUE_DEPTH = 256;
  localparam int ROM_SIZE    = 128;

  // transaction kinds
  localparam logic [1:0] KIND_RX   = 2'd0;
  localparam logic [1:0] KIND_DEQ  = 2'd1;
  localparam logic [1:0] KIND_PEEK = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX   = 2'd2;

  // packet phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DX   = 3'b010,
    PH_DY   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  key_out;
    logic        key_valid;
    logic        pending;
    logic [8:0]  fill_count;
    logic [11:0] pointer_x;
    logic [11:0] pointer_y;
    logic        key_held;
    logic        dropped;
  } out_t;

  localparam logic [7:0] SCAN_ROM [ROM_SIZE] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h28, 8'h29, 8'h2F, 8'h2A, 8'h37,
    8'h38, 8'h39, 8'h34, 8'h35, 8'h36, 8'h31, 8'h32, 8'h33,
    8'h30, 8'h2E, 8'h0D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic logic [7:0] scan_to_ascii(logic [6:0] code);
    return SCAN_ROM[code];
  endfunction

  // add a signed byte to a position and clamp to 0..limit
  function automatic logic [11:0] move_clamped(logic [11:0] pos, logic [7:0] delta,
                                               logic [11:0] limit);
    logic signed [13:0] sum;
    sum = $signed({2'b00, pos}) + $signed({{6{delta[7]}}, delta});
    if (sum < 0) begin
      return '0;
    end else if (sum[12:0] > {1'b0, limit}) begin
      return limit;
    end else begin
      return sum[11:0];
    end
  endfunction

endpackage

// ===== rtl/core/kmpd_ram.sv =====
// ----------------------------------------------------------------------------
// kmpd_ram
// generic single-clock ram, one write and one registered read port
// ----------------------------------------------------------------------------
module kmpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/keyboard_mouse_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// keyboard_mouse_packet_decoder
// keyboard controller byte decoder with key queue and clamped pointer
// ----------------------------------------------------------------------------
// One transaction is taken per clock cycle unless stalled, and every
// transaction returns exactly one result. The rate is set by the update of
// the phase, queue pointers and pointer position, and by the key queue ram,
// which sees at most one access (a push or a read) per transaction. A
// received byte in the idle phase is either a key code (make codes go
// through the scan table into the queue and set the held flag, break codes
// clear it) or a mouse header, which is queued raw and opens a dx/dy
// packet. Dequeue and peek return the head entry with key_valid set, or
// zero with key_valid low when the queue is empty. Queue contents are not
// cleared at reset; the fill count alone decides what is readable, so the
// block is ready right after reset. The user writes configuration through
// a plain write port only while idle (unenforced); index 3 is ignored.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyboard_mouse_packet_decoder #(
  parameter int TABLE_ENTRIES = 115
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request transactions
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  kmpd_pkg::in_t                    in_data_i,
  // result transactions
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output kmpd_pkg::out_t                   out_data_o,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [kmpd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [kmpd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int IdxW = $clog2(kmpd_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(kmpd_pkg::QUEUE_DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx   = IdxW'(kmpd_pkg::QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCount = CntW'(kmpd_pkg::QUEUE_DEPTH);
  localparam logic [8:0]      TableLimit = 9'(TABLE_ENTRIES);

  // configuration registers
  logic [7:0]  hdr_min_q;
  logic [11:0] x_max_q, y_max_q;

  // decoder state
  kmpd_pkg::phase_e phase_q, phase_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d, wr_idx_q, wr_idx_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [11:0]      pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic             held_q, held_d;

  // pipeline: stage one waits for ram data, then the output register
  logic             s1_valid_q;
  logic             s1_rd_q;
  kmpd_pkg::out_t   s1_res_q, s1_res_d;
  logic             out_valid_q;
  kmpd_pkg::out_t   out_data_q, out_data_d;
  logic             s1_adv;
  logic             accept;

  // per-transaction decode
  logic        is_rx, is_read, is_hdr, is_make, is_break;
  logic        push_req, do_push, do_read, do_pop, drop;
  logic        full;
  logic [7:0]  push_data, rom_code;
  logic [7:0]  ram_rdata;

  // ------------------------------------------------------------------
  // handshake
  // ------------------------------------------------------------------
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  // ------------------------------------------------------------------
  // configuration
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_min_q <= 8'd248;
      x_max_q   <= 12'd640;
      y_max_q   <= 12'd400;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kmpd_pkg::REG_HDR_MIN: hdr_min_q <= cfg_data_i[7:0];
        kmpd_pkg::REG_X_MAX:   x_max_q   <= cfg_data_i;
        kmpd_pkg::REG_Y_MAX:   y_max_q   <= cfg_data_i;
        default: ;  // no register behind this index
      endcase
    end
  end

  // ------------------------------------------------------------------
  // decode and state update
  // ------------------------------------------------------------------
  assign is_rx    = in_data_i.kind == kmpd_pkg::KIND_RX;
  assign is_read  = (in_data_i.kind == kmpd_pkg::KIND_DEQ) ||
                    (in_data_i.kind == kmpd_pkg::KIND_PEEK);
  assign is_hdr   = in_data_i.rx_byte >= hdr_min_q;
  assign is_make  = !is_hdr && !in_data_i.rx_byte[7];
  assign is_break = !is_hdr && in_data_i.rx_byte[7];
  assign full     = cnt_q == FullCount;

  // codes past the table map to zero, which is still queued
  assign rom_code  = ({1'b0, in_data_i.rx_byte} < TableLimit) ?
                     kmpd_pkg::scan_to_ascii(in_data_i.rx_byte[6:0]) : 8'h00;
  assign push_data = is_hdr ? in_data_i.rx_byte : rom_code;

  assign push_req = is_rx && (phase_q == kmpd_pkg::PH_IDLE) && (is_hdr || is_make);
  assign do_push  = push_req && !full;
  assign drop     = push_req && full;
  assign do_read  = is_read && (cnt_q != '0);
  assign do_pop   = do_read && (in_data_i.kind == kmpd_pkg::KIND_DEQ);

  always_comb begin
    phase_d  = phase_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    held_d   = held_q;
    rd_idx_d = rd_idx_q;
    wr_idx_d = wr_idx_q;
    cnt_d    = cnt_q;

    if (is_rx) begin
      unique case (phase_q)
        kmpd_pkg::PH_IDLE: begin
          if (is_hdr) begin
            phase_d = kmpd_pkg::PH_DX;
          end else if (is_make) begin
            held_d = 1'b1;
          end else if (is_break) begin
            held_d = 1'b0;
          end
        end
        kmpd_pkg::PH_DX: begin
          pos_x_d = kmpd_pkg::move_clamped(pos_x_q, in_data_i.rx_byte, x_max_q);
          phase_d = kmpd_pkg::PH_DY;
        end
        default: begin
          // dy phase, and any stray code treated the same way
          pos_y_d = kmpd_pkg::move_clamped(pos_y_q, in_data_i.rx_byte, y_max_q);
          phase_d = kmpd_pkg::PH_IDLE;
        end
      endcase
    end

    // push and pop never fall in the same transaction
    if (do_push) begin
      wr_idx_d = (wr_idx_q == LastIdx) ? '0 : wr_idx_q + 1'b1;
      cnt_d    = cnt_q + 1'b1;
    end else if (do_pop) begin
      rd_idx_d = (rd_idx_q == LastIdx) ? '0 : rd_idx_q + 1'b1;
      cnt_d    = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= kmpd_pkg::PH_IDLE;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      cnt_q    <= '0;
      pos_x_q  <= 12'd320;
      pos_y_q  <= 12'd200;
      held_q   <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      cnt_q    <= cnt_d;
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      held_q   <= held_d;
    end
  end

  // ------------------------------------------------------------------
  // key queue storage
  // ------------------------------------------------------------------
  kmpd_ram #(
    .WIDTH (8),
    .DEPTH (kmpd_pkg::QUEUE_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (accept && do_push),
    .waddr_i (wr_idx_q),
    .wdata_i (push_data),
    .re_i    (accept && do_read),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // ------------------------------------------------------------------
  // result pipeline
  // ------------------------------------------------------------------
  // status fields reflect the state after this transaction
  always_comb begin
    s1_res_d            = '0;
    s1_res_d.pending    = cnt_d != '0;
    s1_res_d.fill_count = cnt_d;
    s1_res_d.pointer_x  = pos_x_d;
    s1_res_d.pointer_y  = pos_y_d;
    s1_res_d.key_held   = held_d;
    s1_res_d.dropped    = drop;
  end

  // merge the queue entry into the stage one status
  always_comb begin
    out_data_d           = s1_res_q;
    out_data_d.key_out   = s1_rd_q ? ram_rdata : 8'h00;
    out_data_d.key_valid = s1_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // ram data stays put while stage one holds, since no read is issued then
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= s1_res_d;
      s1_rd_q  <= do_read;
    end
    if (s1_adv && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  `ASSERT_AT(a_read_not_empty, clk_i, rst_ni, (accept && do_read) |-> (cnt_q != '0))
  `ASSERT_AT(a_push_not_full, clk_i, rst_ni, (accept && do_push) |-> (cnt_q != FullCount))
  `ASSERT_NEVER(a_push_and_read, clk_i, rst_ni, accept && do_push && do_read)
  `ASSERT_AT(a_count_tracks, clk_i, rst_ni, (accept && do_push) |=> (cnt_q == $past(cnt_q) + 1'b1))

endmodule
